/* src/assert_macros.svh */
// assertion macros for the text parser checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stp_pkg.sv */
// shared constants and character decode for the saturating int32 text parser
// no dependencies
package stp_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned ValW = 32;
  localparam int unsigned AccW = 31;

  localparam logic [AccW-1:0] MagMax   = {AccW{1'b1}};
  localparam logic [ValW-1:0] ValueMin = {1'b1, {(ValW-1){1'b0}}};

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChPlus  = 8'h2B;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChLowX  = 8'h78;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;

  typedef struct packed {
    logic       is_dec;
    logic       is_hex;
    logic [3:0] val;
  } digit_t;

  function automatic logic is_white(input logic [ChW-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
  endfunction

  function automatic digit_t decode_digit(input logic [ChW-1:0] c);
    digit_t d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.is_dec = 1'b1;
      d.is_hex = 1'b1;
      d.val    = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.is_hex = 1'b1;
      d.val    = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.is_hex = 1'b1;
      d.val    = 4'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

/* src/stp_in_if.sv */
// character channel into the text parser: valid, ready and one byte
// depends on stp_pkg
interface stp_in_if;
  logic                     valid;
  logic                     ready;
  logic [stp_pkg::ChW-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* src/stp_out_if.sv */
// result channel out of the text parser: valid, ready, ok flag and value
// depends on stp_pkg
interface stp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic signed [stp_pkg::ValW-1:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink   (input valid, input ok, input value, output ready);
endinterface

/* src/saturating_int32_text_parser.sv */
// a result word is valid in the cycle after its terminator byte is accepted
// throughput: one character word per cycle; parse state and result register update
// in the same cycle, and a held result only stalls input while it is not taken
// reset: rst_ni asynchronous, active low; clears the parse state and the result valid
// depends on stp_pkg, stp_in_if, stp_out_if
module saturating_int32_text_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o
);

  typedef enum logic [2:0] {
    PhLead   = 3'd0,
    PhSign   = 3'd1,
    PhZero   = 3'd2,
    PhX      = 3'd3,
    PhDigits = 3'd4,
    PhTrail  = 3'd5,
    PhReject = 3'd6
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic                       minus_q, minus_d;
  logic                       hex_q, hex_d;
  logic [stp_pkg::AccW-1:0]   acc_q, acc_d;
  logic                       sat_q, sat_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_ok_q, out_ok_d;
  logic [stp_pkg::ValW-1:0]   out_value_q, out_value_d;

  logic                       accept;
  logic                       white;
  stp_pkg::digit_t            dig;
  logic                       use_hex;
  logic [stp_pkg::AccW+3:0]   acc_mul;
  logic [stp_pkg::AccW+4:0]   acc_sum;
  logic                       acc_ovf;
  logic [stp_pkg::AccW-1:0]   acc_next;
  logic                       good;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.ok    = out_ok_q;
  assign out_o.value = out_value_q;

  // digit datapath: acc * base + digit, saturated
  assign white   = stp_pkg::is_white(in_i.ch);
  assign dig     = stp_pkg::decode_digit(in_i.ch);
  assign use_hex = hex_q || (phase_q == PhX);
  assign acc_mul = use_hex ? {acc_q, 4'b0000}
                           : ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0});
  assign acc_sum  = {1'b0, acc_mul} + {{(stp_pkg::AccW+1){1'b0}}, dig.val};
  assign acc_ovf  = acc_sum > {5'b00000, stp_pkg::MagMax};
  assign acc_next = acc_ovf ? stp_pkg::MagMax : acc_sum[stp_pkg::AccW-1:0];
  assign good     = (phase_q == PhZero) || (phase_q == PhDigits) || (phase_q == PhTrail);

  always_comb begin
    phase_d     = phase_q;
    minus_d     = minus_q;
    hex_d       = hex_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_ok_d    = out_ok_q;
    out_value_d = out_value_q;
    if (accept) begin
      if (in_i.ch == stp_pkg::ChNul) begin
        out_valid_d = 1'b1;
        out_ok_d    = good;
        if (!good) begin
          out_value_d = '0;
        end else if (minus_q && sat_q) begin
          out_value_d = stp_pkg::ValueMin;
        end else if (minus_q) begin
          out_value_d = '0 - {1'b0, acc_q};
        end else begin
          out_value_d = {1'b0, acc_q};
        end
        phase_d = PhLead;
        minus_d = 1'b0;
        hex_d   = 1'b0;
        acc_d   = '0;
        sat_d   = 1'b0;
      end else begin
        case (phase_q)
          PhLead, PhSign: begin
            if (phase_q == PhLead && white) begin
              phase_d = PhLead;
            end else if (phase_q == PhLead &&
                         (in_i.ch == stp_pkg::ChPlus || in_i.ch == stp_pkg::ChMinus)) begin
              minus_d = (in_i.ch == stp_pkg::ChMinus);
              phase_d = PhSign;
            end else if (!dig.is_dec) begin
              phase_d = PhReject;
            end else if (dig.val == 4'd0) begin
              acc_d   = '0;
              phase_d = PhZero;
            end else begin
              acc_d   = acc_next;
              sat_d   = sat_q || acc_ovf;
              phase_d = PhDigits;
            end
          end
          PhZero: begin
            if (in_i.ch == stp_pkg::ChLowX || in_i.ch == stp_pkg::ChUpX) begin
              phase_d = PhX;
            end else if (white) begin
              phase_d = PhTrail;
            end else if (!dig.is_dec) begin
              phase_d = PhReject;
            end else begin
              acc_d   = acc_next;
              sat_d   = sat_q || acc_ovf;
              phase_d = PhDigits;
            end
          end
          PhX: begin
            if (!dig.is_hex) begin
              phase_d = PhReject;
            end else begin
              hex_d   = 1'b1;
              acc_d   = acc_next;
              sat_d   = sat_q || acc_ovf;
              phase_d = PhDigits;
            end
          end
          PhDigits: begin
            if (white) begin
              phase_d = PhTrail;
            end else if (!(hex_q ? dig.is_hex : dig.is_dec)) begin
              phase_d = PhReject;
            end else begin
              acc_d = acc_next;
              sat_d = sat_q || acc_ovf;
            end
          end
          PhTrail: begin
            if (!white) begin
              phase_d = PhReject;
            end
          end
          default: begin
            phase_d = PhReject;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      minus_q     <= 1'b0;
      hex_q       <= 1'b0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_value_q <= '0;
    end else begin
      phase_q     <= phase_d;
      minus_q     <= minus_d;
      hex_q       <= hex_d;
      acc_q       <= acc_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_value_q <= out_value_d;
    end
  end

endmodule

/* src/stp_checker.sv */
// port-level checker for the saturating int32 text parser, bound to the top level
// depends on stp_pkg and assert_macros.svh
`include "assert_macros.svh"

module stp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic [stp_pkg::ChW-1:0]         in_ch_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            out_ok_i,
  input logic signed [stp_pkg::ValW-1:0] out_value_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `STP_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_ok_i) && $stable(out_value_i), "result word changed while stalled")
  `STP_ASSERT_IMP(a_reject_zero, out_valid_i && !out_ok_i, out_value_i == '0, "rejected word carries nonzero value")
  `STP_ASSERT_NXT(a_term_result, in_acc && in_ch_i == stp_pkg::ChNul, out_valid_i, "terminator gave no result word")
  `STP_ASSERT_NXT(a_char_silent, in_acc && in_ch_i != stp_pkg::ChNul && !out_valid_i, !out_valid_i, "result word without terminator")
  `STP_ASSERT_IMP(a_ready_free, !out_valid_i, in_ready_i, "input stalled with empty result register")

endmodule

bind saturating_int32_text_parser stp_checker u_stp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_ch_i     (in_i.ch),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ok_i    (out_o.ok),
  .out_value_i (out_o.value)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for saturating_int32_text_parser: strings go in one byte per word
// and each terminator's ok/value word is checked against an in-bench parser
// depends on stp_pkg, stp_in_if, stp_out_if and the parser rtl
module testbench;

  localparam int DecRadix = 10;
  localparam int HexRadix = 16;
  localparam int RandomChars = 1000;

  typedef enum logic [2:0] {
    PhLead, PhSign, PhZero, PhX, PhDigits, PhTrail, PhReject
  } parse_phase_e;

  typedef struct packed {
    logic                            ok;
    logic signed [stp_pkg::ValW-1:0] value;
  } parse_result_t;

  logic clk_i;
  logic rst_ni;

  stp_in_if  in_if ();
  stp_out_if out_if ();

  saturating_int32_text_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [stp_pkg::ChW-1:0] pending_chars[$];
  parse_result_t  parsed_results[$];
  int unsigned    mismatches;

  parse_phase_e   phase;
  logic           neg;
  logic           hex;
  logic [stp_pkg::AccW-1:0] mag;
  logic           sat;

  logic           in_fire;
  logic           out_fire;
  int unsigned    in_gap;
  int unsigned    in_calm;
  int unsigned    out_hold;
  int unsigned    out_calm;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic is_blank(input logic [stp_pkg::ChW-1:0] c);
    return c == " " || c == "\t" || c == "\n" || c == "\r" || c == "\014" || c == "\013";
  endfunction

  function automatic int char_digit(input logic [stp_pkg::ChW-1:0] c, input int radix);
    int v;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    else return -1;
    return (v < radix) ? v : -1;
  endfunction

  task automatic clear_parse();
    phase = PhLead;
    neg   = 1'b0;
    hex   = 1'b0;
    mag   = '0;
    sat   = 1'b0;
  endtask

  task automatic add_digit(input int d);
    logic [35:0] grown;
    grown = 36'(mag) * (hex ? 36'(HexRadix) : 36'(DecRadix)) + 36'(d);
    if (grown > 36'(stp_pkg::MagMax)) begin
      sat = 1'b1;
      mag = stp_pkg::MagMax;
    end else begin
      mag = grown[stp_pkg::AccW-1:0];
    end
  endtask

  task automatic take_first_digit(input logic [stp_pkg::ChW-1:0] c);
    int d;
    d = char_digit(c, DecRadix);
    if (d < 0) begin
      phase = PhReject;
    end else if (d == 0) begin
      mag   = '0;
      phase = PhZero;
    end else begin
      add_digit(d);
      phase = PhDigits;
    end
  endtask

  task automatic parse_char(input logic [stp_pkg::ChW-1:0] c);
    int            d;
    parse_result_t res;
    if (c == stp_pkg::ChNul) begin
      res.ok    = (phase == PhZero || phase == PhDigits || phase == PhTrail);
      res.value = '0;
      if (res.ok) begin
        if (neg && sat) res.value = stp_pkg::ValueMin;
        else if (neg) res.value = 32'd0 - {1'b0, mag};
        else res.value = {1'b0, mag};
      end
      parsed_results.push_back(res);
      clear_parse();
      return;
    end
    case (phase)
      PhLead: begin
        if (!is_blank(c)) begin
          if (c == stp_pkg::ChPlus || c == stp_pkg::ChMinus) begin
            neg   = (c == stp_pkg::ChMinus);
            phase = PhSign;
          end else begin
            take_first_digit(c);
          end
        end
      end
      PhSign: take_first_digit(c);
      PhZero: begin
        d = char_digit(c, DecRadix);
        if (c == stp_pkg::ChLowX || c == stp_pkg::ChUpX) phase = PhX;
        else if (is_blank(c)) phase = PhTrail;
        else if (d < 0) phase = PhReject;
        else begin
          add_digit(d);
          phase = PhDigits;
        end
      end
      PhX: begin
        d = char_digit(c, HexRadix);
        if (d < 0) begin
          phase = PhReject;
        end else begin
          hex = 1'b1;
          mag = '0;
          add_digit(d);
          phase = PhDigits;
        end
      end
      PhDigits: begin
        d = char_digit(c, hex ? HexRadix : DecRadix);
        if (is_blank(c)) phase = PhTrail;
        else if (d < 0) phase = PhReject;
        else add_digit(d);
      end
      PhTrail: if (!is_blank(c)) phase = PhReject;
      default: phase = PhReject;
    endcase
  endtask

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [stp_pkg::ChW-1:0] rand_blank();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return "\t";
      2: return "\n";
      3: return "\r";
      4: return "\014";
      default: return "\013";
    endcase
  endfunction

  function automatic logic [stp_pkg::ChW-1:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [stp_pkg::ChW-1:0] rand_dec_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [stp_pkg::ChW-1:0] rand_token();
    case ($urandom_range(0, 6))
      0: return rand_blank();
      1: return $urandom_range(0, 1) ? stp_pkg::ChPlus : stp_pkg::ChMinus;
      2: return rand_dec_char();
      3: return $urandom_range(0, 1) ? stp_pkg::ChLowX : stp_pkg::ChUpX;
      4: return rand_hex_char();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    pending_chars.push_back(stp_pkg::ChNul);
  endtask

  task automatic queue_random_text();
    logic [stp_pkg::ChW-1:0] text[$];
    int unsigned    kind;
    int unsigned    n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = $urandom_range(0, 3);
      repeat (n) text.push_back(rand_blank());
      case ($urandom_range(0, 2))
        1: text.push_back(stp_pkg::ChPlus);
        2: text.push_back(stp_pkg::ChMinus);
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) begin
        text.push_back("0");
        text.push_back($urandom_range(0, 1) ? stp_pkg::ChLowX : stp_pkg::ChUpX);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
        repeat (n) text.push_back(rand_hex_char());
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
        repeat (n) text.push_back(rand_dec_char());
      end
      n = $urandom_range(0, 2);
      repeat (n) text.push_back(rand_blank());
      if ($urandom_range(0, 7) == 0) text[$urandom_range(0, text.size() - 1)] = rand_token();
    end else if (kind < 85) begin
      n = $urandom_range(0, 8);
      repeat (n) text.push_back(rand_token());
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          text.push_back($urandom_range(0, 1) ? stp_pkg::ChPlus : stp_pkg::ChMinus);
          n = $urandom_range(0, 2);
          repeat (n) text.push_back(rand_blank());
        end
        1: begin
          text.push_back("0");
          text.push_back($urandom_range(0, 1) ? stp_pkg::ChLowX : stp_pkg::ChUpX);
          if ($urandom_range(0, 1)) text.push_back($urandom_range(0, 1) ? "g" : rand_blank());
        end
        2: begin
          text.push_back($urandom_range(0, 1) ? stp_pkg::ChPlus : stp_pkg::ChMinus);
          text.push_back(rand_blank());
          text.push_back(rand_dec_char());
        end
        default: begin
          text.push_back(rand_dec_char());
          text.push_back(rand_blank());
          text.push_back(rand_token());
        end
      endcase
    end
    foreach (text[i]) pending_chars.push_back(text[i]);
    pending_chars.push_back(stp_pkg::ChNul);
  endtask

  // character driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_fire) in_gap = pick_gap(in_calm);
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap--;
      end else if (pending_chars.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.ch    <= pending_chars.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_hold == 0 && (out_fire || $urandom_range(0, 19) == 0))
        out_hold = pick_gap(out_calm);
      if (out_hold > 0) begin
        out_if.ready <= 1'b0;
        out_hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted bytes, check accepted result words
  always @(posedge clk_i) begin
    parse_result_t want;
    in_fire  <= rst_ni && in_if.valid && in_if.ready;
    out_fire <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) parse_char(in_if.ch);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (parsed_results.size() == 0) begin
        $error("unexpected result word: ok %0d value %0d", out_if.ok, out_if.value);
        mismatches++;
      end else begin
        want = parsed_results.pop_front();
        if (out_if.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_if.ok);
          mismatches++;
        end
        if (out_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", $signed(want.value), out_if.value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    string cases[$];
    int    directed_len;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    out_if.ready = 1'b0;
    in_fire      = 1'b0;
    out_fire     = 1'b0;
    in_gap       = 0;
    in_calm      = 0;
    out_hold     = 0;
    out_calm     = 0;
    mismatches   = 0;
    clear_parse();

    cases = '{"", " \t\n\r\014\013", "0", "2147483647", "2147483648", "-2147483648",
              "-2147483649", "-2147483647", "99999999999", "+42", "-", "+ ", "- 5",
              "0x", "0X ", "0xg", "0x7fffffff", "-0X80000000", "0XFFFFFFFFF",
              "12ab", "abc", "  0x1F \t", "42  x", "-007\013", "\377\200", "1z99"};
    foreach (cases[i]) queue_text(cases[i]);
    directed_len = pending_chars.size();
    while (pending_chars.size() < directed_len + RandomChars) queue_random_text();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_if.valid) @(posedge clk_i);
    while (parsed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS saturating_int32_text_parser");
    end else begin
      $display("FAIL saturating_int32_text_parser");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL saturating_int32_text_parser");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/stp_pkg.sv
src/stp_in_if.sv
src/stp_out_if.sv
src/saturating_int32_text_parser.sv
src/stp_checker.sv
sim/testbench.sv
